### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ciss_pkg.sv
// ---------------------------------------------------------------------------
// ciss_pkg
// Types, codes and helpers of the case-insensitive substring search unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ciss_pkg;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_PATTERN = 2'd0,
    KIND_TEXT    = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_MATCH   = 2'd0,
    STATUS_NOMATCH = 2'd1,
    STATUS_TOOLONG = 2'd2
  } status_t;

  localparam int unsigned OFFSET_W = 32;

  // Input item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0]          status;
    logic [OFFSET_W-1:0] match_offset;
  } out_item_t;

  // Broadcast control from the sequencer to every cell of the chain.
  typedef struct packed {
    logic       wr_en;    // store a pattern byte in the cell at the current length
    logic       step_en;  // advance the prefix match bits by one text byte
    logic       clear;    // drop all prefix match bits
    logic [7:0] ch;       // folded byte (pattern byte or text byte)
  } cell_ctrl_t;

  // Fold ASCII lower case letters onto upper case; other bytes pass unchanged.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= 8'h61) && (c <= 8'h7A)) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ciss_cell.sv
// ---------------------------------------------------------------------------
// ciss_cell
// One pattern position: holds a folded pattern byte and the prefix match
// bit for that position, and hands the bit on to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module ciss_cell #(
  parameter int unsigned LEN_W = 6,
  parameter int unsigned INDEX = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ciss_pkg::cell_ctrl_t  ctrl,
  input  wire logic [LEN_W-1:0]      length,
  input  wire logic                  prev_bit,
  output logic                       match_bit,
  output logic                       hit
);

  logic [7:0] pat_byte_r;
  logic       match_r;
  logic       active;
  logic       is_last;
  logic       cand;

  // Position lies inside the loaded pattern, and is its final position.
  assign active  = LEN_W'(INDEX) < length;
  assign is_last = LEN_W'(INDEX + 1) == length;

  // Prefix through this position matches if the shorter prefix matched
  // at the previous text byte and this byte matches now.
  assign cand = prev_bit & active & (pat_byte_r == ctrl.ch);

  // A completed match of the whole pattern ends in this cell.
  assign hit       = cand & is_last;
  assign match_bit = match_r;

  // Pattern byte storage, written once while the pattern loads.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (length == LEN_W'(INDEX))) begin
      pat_byte_r <= ctrl.ch;
    end
  end

  // Prefix match bit.
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      match_r <= 1'b0;
    end else if (ctrl.step_en) begin
      match_r <= cand;
    end
  end

endmodule

`default_nettype wire

### rtl/core/case_insensitive_substring_search_unit.sv
// ---------------------------------------------------------------------------
// case_insensitive_substring_search_unit
// Result: registered; it appears on out_ in the cycle after the transfer causing it.
// Throughput: one item per cycle when in_ready; each text byte steps all cells.
// Reset: synchronous rst_n clears length, match bits, position and flags.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module case_insensitive_substring_search_unit #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ciss_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ciss_pkg::out_item_t      out_data
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned OFF_W = ciss_pkg::OFFSET_W;

  // Search state.
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [OFF_W-1:0] pos_r, pos_nxt;
  logic             finished_r, finished_nxt;
  logic             overflow_r, overflow_nxt;
  logic             text_r, text_nxt;
  logic             closed_r, closed_nxt;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  ciss_pkg::out_item_t  out_data_r, out_data_nxt;

  logic                  in_fire;
  logic                  emit;
  ciss_pkg::out_item_t   res;
  ciss_pkg::cell_ctrl_t  ctrl;
  logic [MAX_PATTERN:0]  chain;
  logic [MAX_PATTERN-1:0] hit_vec;
  logic                  any_hit;

  // A new item is taken whenever the result register is empty or drains.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Row of cells; the empty prefix always matches at the head.
  assign chain[0] = 1'b1;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    ciss_cell #(
      .LEN_W (LEN_W),
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .length    (len_r),
      .prev_bit  (chain[g]),
      .match_bit (chain[g+1]),
      .hit       (hit_vec[g])
    );
  end

  assign any_hit = |hit_vec;

  // Cell control: pattern writes, text steps and the clear at end of text.
  always_comb begin
    ctrl.ch      = ciss_pkg::fold_case(in_data.byte_value);
    ctrl.wr_en   = in_fire && (in_data.kind == ciss_pkg::KIND_PATTERN) &&
                   !(text_r || closed_r || overflow_r) &&
                   (in_data.byte_value != 8'h00) && (len_r != LEN_W'(MAX_PATTERN));
    ctrl.step_en = in_fire && (in_data.kind == ciss_pkg::KIND_TEXT) && !finished_r &&
                   (len_r != '0) && (in_data.byte_value != 8'h00);
    ctrl.clear   = in_fire && (in_data.kind == ciss_pkg::KIND_END);
  end

  // Sequencer: decode each item into state update and result.
  always_comb begin
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    finished_nxt = finished_r;
    overflow_nxt = overflow_r;
    text_nxt     = text_r;
    closed_nxt   = closed_r;
    emit         = 1'b0;
    res.status       = ciss_pkg::STATUS_MATCH;
    res.match_offset = '0;

    if (in_fire) begin
      case (in_data.kind)
        ciss_pkg::KIND_PATTERN: begin
          if (!(text_r || closed_r || overflow_r)) begin
            if (in_data.byte_value == 8'h00) begin
              closed_nxt = 1'b1;
            end else if (len_r == LEN_W'(MAX_PATTERN)) begin
              overflow_nxt = 1'b1;
              emit         = 1'b1;
              res.status   = ciss_pkg::STATUS_TOOLONG;
            end else begin
              len_nxt    = len_r + LEN_W'(1);
            end
          end
        end
        ciss_pkg::KIND_TEXT: begin
          text_nxt = 1'b1;
          if (!finished_r) begin
            if (len_r == '0) begin
              emit = 1'b1;
            end else if (in_data.byte_value == 8'h00) begin
              emit       = 1'b1;
              res.status = ciss_pkg::STATUS_NOMATCH;
            end else begin
              pos_nxt      = pos_r + OFF_W'(1);
              if (any_hit) begin
                emit             = 1'b1;
                res.match_offset = pos_r + OFF_W'(1) - OFF_W'(len_r);
              end
            end
          end
        end
        ciss_pkg::KIND_END: begin
          if (!finished_r) begin
            emit = 1'b1;
            if (len_r != '0) begin
              res.status = ciss_pkg::STATUS_NOMATCH;
            end
          end
          // End of text returns the unit to idle, keeping the stored bytes.
          len_nxt      = '0;
          pos_nxt      = '0;
          overflow_nxt = 1'b0;
          text_nxt     = 1'b0;
          closed_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
      if (emit) begin
        finished_nxt = 1'b1;
      end
      if (in_data.kind == ciss_pkg::KIND_END) begin
        finished_nxt = 1'b0;
      end
    end
  end

  // Result register: loads on a result, drains on an output transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire && emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pos_r       <= '0;
      finished_r  <= 1'b0;
      overflow_r  <= 1'b0;
      text_r      <= 1'b0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      finished_r  <= finished_nxt;
      overflow_r  <= overflow_nxt;
      text_r      <= text_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Assertions.
  `ASSERT_CLK(a_single_hit, $onehot0(hit_vec), "more than one cell reports a full match")
  `ASSERT_IMPL(a_one_result, in_fire && emit, !finished_r, "second result within one search")
  `ASSERT_IMPL(a_toolong_full, in_fire && emit && (res.status == ciss_pkg::STATUS_TOOLONG),
    len_r == LEN_W'(MAX_PATTERN), "pattern flagged too long with room in the store")
  `ASSERT_NEXT(a_end_clears, in_fire && (in_data.kind == ciss_pkg::KIND_END),
    (len_r == '0) && !finished_r && (pos_r == '0), "end of text left search state behind")

endmodule

`default_nettype wire

### verif/search_checker.sv
// ----------------------------------------------------------------------------
// search_checker
// Watches both channels of the substring search unit. It keeps its own model
// of the pattern store and the shift-and match vector, predicts the result of
// each input transfer and compares every output transfer with the oldest one.
// ----------------------------------------------------------------------------
module search_checker #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ciss_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ciss_pkg::out_item_t out_data,
  output int unsigned         fail_count,
  output int unsigned         pending
);

  // Model state of one search.
  logic [7:0]             pat_bytes [MAX_PATTERN];
  logic [6:0]             pat_len;
  logic [MAX_PATTERN-1:0] prefix_bits;
  logic [31:0]            text_pos;
  bit                     result_given;
  bit                     overflowed;
  bit                     text_phase;
  bit                     pat_closed;

  // Search results still to come out of the block, oldest first.
  ciss_pkg::out_item_t result_q[$];

  // Letters a-z compare equal to A-Z; every other byte stands for itself.
  function automatic logic [7:0] upper_byte(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) ? (c ^ 8'h20) : c;
  endfunction

  task automatic clear_search();
    pat_len      = '0;
    prefix_bits  = '0;
    text_pos     = '0;
    result_given = 1'b0;
    overflowed   = 1'b0;
    text_phase   = 1'b0;
    pat_closed   = 1'b0;
  endtask

  task automatic post_result(input ciss_pkg::status_t s, input logic [31:0] ofs);
    result_q.push_back('{status: s, match_offset: ofs});
    result_given = 1'b1;
  endtask

  // Advance the model by one accepted input item.
  task automatic search_step(input ciss_pkg::in_item_t it);
    logic [MAX_PATTERN-1:0] eq;
    logic [7:0]             fc;
    case (it.kind)
      ciss_pkg::KIND_PATTERN: begin
        if (!(text_phase || pat_closed || overflowed)) begin
          if (it.byte_value == 8'h00) begin
            pat_closed = 1'b1;
          end else if (pat_len >= MAX_PATTERN) begin
            overflowed = 1'b1;
            post_result(ciss_pkg::STATUS_TOOLONG, '0);
          end else begin
            pat_bytes[pat_len] = it.byte_value;
            pat_len = pat_len + 1'b1;
          end
        end
      end
      ciss_pkg::KIND_TEXT: begin
        text_phase = 1'b1;
        if (!result_given) begin
          if (pat_len == 0) begin
            post_result(ciss_pkg::STATUS_MATCH, '0);
          end else if (it.byte_value == 8'h00) begin
            post_result(ciss_pkg::STATUS_NOMATCH, '0);
          end else begin
            fc = upper_byte(it.byte_value);
            eq = '0;
            for (int i = 0; i < pat_len; i++) begin
              eq[i] = (upper_byte(pat_bytes[i]) == fc);
            end
            prefix_bits = ((prefix_bits << 1) | 1) & eq;
            text_pos    = text_pos + 1;
            if (prefix_bits[pat_len-1]) begin
              post_result(ciss_pkg::STATUS_MATCH, text_pos - 32'(pat_len));
            end
          end
        end
      end
      ciss_pkg::KIND_END: begin
        if (!result_given) begin
          post_result((pat_len == 0) ? ciss_pkg::STATUS_MATCH : ciss_pkg::STATUS_NOMATCH,
                      '0);
        end
        clear_search();
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input ciss_pkg::out_item_t want,
                                 input ciss_pkg::out_item_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected status %0d offset %0d, got status %0d offset %0d",
               $realtime, what, want.status, want.match_offset,
               got.status, got.match_offset);
    end
  endtask

  // Compare output transfers first: a result never leaves in the same
  // cycle as the input transfer that causes it.
  always @(posedge clk) begin
    ciss_pkg::out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        pat_bytes[i] = '0;
      end
      clear_search();
      result_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with none expected", '0, out_data);
        end else begin
          want = result_q.pop_front();
          if (out_data.status != want.status ||
              out_data.match_offset != want.match_offset) begin
            report_mismatch("wrong result", want, out_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        search_step(in_data);
      end
    end
    pending = result_q.size();
  end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the case-insensitive substring search unit with a directed set of
// corner searches and then with random searches: short patterns over a small
// alphabet of letters and letter-border bytes, embedded into texts with mixed
// case, plus over-long patterns, zero bytes and stray items. Both channels
// stall at random. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned PATTERN_DEPTH = 32;
  localparam int          RANDOM_ITEMS  = 1450;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  ciss_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  ciss_pkg::out_item_t out_data;
  int unsigned         fail_count;
  int unsigned         pending;

  bit idle_on;
  int sent_count;
  int stall_left;

  case_insensitive_substring_search_unit #(
    .MAX_PATTERN(PATTERN_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  search_checker #(
    .MAX_PATTERN(PATTERN_DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("[case_insensitive_substring_search_unit] ERROR");
    $finish;
  end

  // Result side: random stall bursts while idling is on, otherwise always ready.
  initial begin
    out_ready  = 1'b1;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 5);
        end
      end
    end
  end

  // One transfer on the input channel. Called and left at a falling edge.
  task automatic send_item(input logic [1:0] k, input logic [7:0] b,
                           input bit counted = 1'b1);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: k, byte_value: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (counted) sent_count++;
  endtask

  // Mostly letters and the bytes just around the letter ranges, so that
  // folding is stressed; now and then any nonzero byte.
  function automatic logic [7:0] pick_char();
    logic [7:0] alphabet [10] = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h40,
                                  8'h5B, 8'h60, 8'h7B, 8'h7A, 8'h5A};
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(1, 255));
    return alphabet[$urandom_range(0, 9)];
  endfunction

  // Flip the case of a letter at random.
  function automatic logic [7:0] mix_case(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (lc >= 8'h61 && lc <= 8'h7A && $urandom_range(0, 1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  // One search: a pattern, a text that often holds the pattern, the end item.
  task automatic random_search();
    logic [7:0] pat [$];
    logic [7:0] txt [$];
    int         mode;
    int         plen;
    int         tlen;
    int         at;
    mode = $urandom_range(0, 99);
    if (mode < 4) plen = 0;
    else if (mode < 10) plen = $urandom_range(PATTERN_DEPTH - 2, PATTERN_DEPTH + 2);
    else plen = $urandom_range(1, 5);
    for (int i = 0; i < plen; i++) pat.push_back(pick_char());
    foreach (pat[i]) send_item(ciss_pkg::KIND_PATTERN, pat[i]);

    // A zero byte closes the pattern; anything after it is dropped.
    if ($urandom_range(0, 9) == 0) begin
      send_item(ciss_pkg::KIND_PATTERN, 8'h00);
      repeat ($urandom_range(1, 2)) send_item(ciss_pkg::KIND_PATTERN, pick_char(), 1'b0);
    end

    tlen = $urandom_range(0, 20) + ((plen > 8) ? plen : 0);
    for (int i = 0; i < tlen; i++) txt.push_back(pick_char());
    if (plen > 0 && plen <= PATTERN_DEPTH && $urandom_range(0, 9) < 7) begin
      at = $urandom_range(0, tlen);
      foreach (pat[i]) txt.insert(at + i, mix_case(pat[i]));
    end

    foreach (txt[i]) begin
      case ($urandom_range(0, 39))
        0: send_item(ciss_pkg::KIND_PATTERN, pick_char(), 1'b0);
        1: send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'b0);
        2: send_item(ciss_pkg::KIND_TEXT, 8'h00);
        default: begin
        end
      endcase
      send_item(ciss_pkg::KIND_TEXT, txt[i]);
    end
    if ($urandom_range(0, 19) != 0) send_item(ciss_pkg::KIND_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    idle_on  = 1'b1;
    sent_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty pattern: the first text byte matches at zero, later text is dropped.
    send_item(ciss_pkg::KIND_TEXT, 8'hFF);
    send_item(ciss_pkg::KIND_TEXT, 8'h78);
    send_item(ciss_pkg::KIND_END, 8'h00);
    // Empty pattern ended at once still matches at zero.
    send_item(ciss_pkg::KIND_END, 8'hFF);
    // Mixed-case pattern closed by a zero byte, found in mixed-case text.
    send_item(ciss_pkg::KIND_PATTERN, 8'h61);
    send_item(ciss_pkg::KIND_PATTERN, 8'h42);
    send_item(ciss_pkg::KIND_PATTERN, 8'h00);
    send_item(ciss_pkg::KIND_PATTERN, 8'h51);
    send_item(ciss_pkg::KIND_TEXT, 8'h78);
    send_item(ciss_pkg::KIND_TEXT, 8'h41);
    send_item(ciss_pkg::KIND_TEXT, 8'h62);
    send_item(ciss_pkg::KIND_END, 8'h00);
    // Unused kind and a late pattern byte are dropped; a zero text byte ends
    // the text with no match, and the text after it gives nothing.
    send_item(ciss_pkg::KIND_PATTERN, 8'hFF);
    send_item(ciss_pkg::KIND_TEXT, 8'h80);
    send_item(KIND_UNUSED, 8'hFF);
    send_item(ciss_pkg::KIND_PATTERN, 8'h01);
    send_item(ciss_pkg::KIND_TEXT, 8'h00);
    send_item(ciss_pkg::KIND_TEXT, 8'hFF);
    send_item(ciss_pkg::KIND_END, 8'h00);
    // Bytes beside the letter ranges do not fold onto each other.
    send_item(ciss_pkg::KIND_PATTERN, 8'h40);
    send_item(ciss_pkg::KIND_TEXT, 8'h60);
    send_item(ciss_pkg::KIND_END, 8'h00);

    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if (sent_count > RANDOM_ITEMS - 150) idle_on = 1'b0;
      random_search();
    end
    idle_on = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[case_insensitive_substring_search_unit] OK");
    end else begin
      $display("[case_insensitive_substring_search_unit] ERROR");
    end
    $finish;
  end

endmodule
